>>> design/telnet_rx_line_assembler_assert.svh
// Assertion macros used by the telnet receive line assembler.
`ifndef TELNET_RX_LINE_ASSEMBLER_ASSERT_SVH
`define TELNET_RX_LINE_ASSEMBLER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define TRA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define TRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/tra_pkg.sv
// Types and constants shared by the telnet receive line assembler.
package tra_pkg;

	localparam int LINE_LEN_DEF = 32;
	localparam int QUEUE_DEPTH  = 4;
	localparam int CHAR_W       = 7;

	// telnet command and option codes
	localparam logic [7:0] TN_IAC  = 8'd255;
	localparam logic [7:0] TN_DONT = 8'd254;
	localparam logic [7:0] TN_DO   = 8'd253;
	localparam logic [7:0] TN_WONT = 8'd252;
	localparam logic [7:0] TN_WILL = 8'd251;
	localparam logic [7:0] TN_EL   = 8'd248;
	localparam logic [7:0] TN_EC   = 8'd247;
	localparam logic [7:0] TN_AYT  = 8'd246;
	localparam logic [7:0] TN_IP   = 8'd244;

	localparam logic [7:0] OPT_ECHO = 8'd1;
	localparam logic [7:0] OPT_SGA  = 8'd3;
	localparam logic [7:0] OPT_EOR  = 8'd25;

	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CTL   = 8'd31;
	localparam logic [7:0] CH_DEL   = 8'd127;

	// result kinds
	localparam logic [2:0] KIND_REPLY = 3'd0;
	localparam logic [2:0] KIND_ECHO  = 3'd1;
	localparam logic [2:0] KIND_LINE  = 3'd2;
	localparam logic [2:0] KIND_AYT   = 3'd3;
	localparam logic [2:0] KIND_IP    = 3'd4;

	typedef enum logic [2:0] {
		OP_REPLY = 3'd0,
		OP_STORE = 3'd1,
		OP_DUMP  = 3'd2,
		OP_AYT   = 3'd3,
		OP_IP    = 3'd4
	} op_t;

	// one request from the parser to the executor
	typedef struct packed {
		op_t        op;
		logic [7:0] verb;
		logic [7:0] value;  // option code or character
		logic       echo;
		logic       trunc;
	} cmd_t;

endpackage

>>> design/tra_ram.sv
// Generic simple dual-port RAM with registered read.
module tra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/tra_queue.sv
// Small request queue between the parser and the executor.
module tra_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    fill_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full  = (fill_q == NW'(DEPTH));
	assign empty = (fill_q == '0);
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + NW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - NW'(1);
			end
		end
	end

endmodule

>>> design/tra_front.sv
// Byte parser: telnet command decode, echo flag, line count bookkeeping.
module tra_front
	import tra_pkg::*;
#(
	parameter int LINE_LEN = LINE_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [7:0]                    rx_byte,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          q_full,
	output logic                          q_push,
	output cmd_t                          q_cmd,
	output logic [$clog2(LINE_LEN+1)-1:0] q_cnt
);

	localparam int CW = $clog2(LINE_LEN + 1);

	localparam logic [2:0] PH_DATA = 3'd0;
	localparam logic [2:0] PH_CMD  = 3'd1;
	localparam logic [2:0] PH_DO   = 3'd2;
	localparam logic [2:0] PH_DONT = 3'd3;
	localparam logic [2:0] PH_WILL = 3'd4;
	localparam logic [2:0] PH_WONT = 3'd5;

	logic [2:0]    phase_q, phase_d;
	logic [CW-1:0] count_q, count_d;
	logic          trunc_q, trunc_d;
	logic          echo_q, echo_d;
	logic          accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		phase_d     = phase_q;
		count_d     = count_q;
		trunc_d     = trunc_q;
		echo_d      = echo_q;
		q_push      = 1'b0;
		q_cmd.op    = OP_REPLY;
		q_cmd.verb  = '0;
		q_cmd.value = rx_byte;
		q_cmd.echo  = echo_q;
		q_cmd.trunc = trunc_q;
		q_cnt       = count_q;
		if (accept) begin
			phase_d = PH_DATA;
			unique case (phase_q)
				PH_CMD: begin
					unique case (rx_byte)
						TN_AYT: begin
							q_push   = 1'b1;
							q_cmd.op = OP_AYT;
						end
						TN_IP: begin
							q_push   = 1'b1;
							q_cmd.op = OP_IP;
						end
						TN_EC: begin
							if (count_q != '0) begin
								count_d = count_q - CW'(1);
							end
						end
						TN_EL: begin
							count_d = '0;
							trunc_d = 1'b0;
						end
						TN_DO:   phase_d = PH_DO;
						TN_DONT: phase_d = PH_DONT;
						TN_WILL: phase_d = PH_WILL;
						TN_WONT: phase_d = PH_WONT;
						default: phase_d = PH_DATA;
					endcase
				end
				PH_DO: begin
					q_push = 1'b1;
					if (rx_byte == OPT_SGA || rx_byte == OPT_EOR || rx_byte == OPT_ECHO) begin
						q_cmd.verb = TN_WILL;
					end else begin
						q_cmd.verb = TN_WONT;
					end
					if (rx_byte == OPT_ECHO) begin
						echo_d = 1'b1;
					end
				end
				PH_DONT: begin
					if (rx_byte == OPT_ECHO) begin
						echo_d = 1'b0;
					end
				end
				PH_WILL: begin
					q_push     = 1'b1;
					q_cmd.verb = TN_DONT;
				end
				PH_WONT: phase_d = PH_DATA;
				default: begin
					if (rx_byte == TN_IAC) begin
						phase_d = PH_CMD;
					end else if (rx_byte == CH_LF) begin
						q_push   = 1'b1;
						q_cmd.op = OP_DUMP;
						count_d  = '0;
						trunc_d  = 1'b0;
					end else if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
						if (count_q != '0) begin
							count_d = count_q - CW'(1);
						end
					end else if (rx_byte > CH_CTL && rx_byte < CH_DEL) begin
						if (count_q >= CW'(LINE_LEN)) begin
							trunc_d = 1'b1;
						end else begin
							// q_cnt carries the write index
							q_push   = 1'b1;
							q_cmd.op = OP_STORE;
							count_d  = count_q + CW'(1);
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DATA;
			count_q <= '0;
			trunc_q <= 1'b0;
			echo_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			trunc_q <= trunc_d;
			echo_q  <= echo_d;
		end
	end

endmodule

>>> design/tra_back.sv
// Executor: owns the line store, builds result items, streams line dumps.
module tra_back
	import tra_pkg::*;
#(
	parameter int LINE_LEN = LINE_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  cmd_t                          q_cmd,
	input  logic [$clog2(LINE_LEN+1)-1:0] q_cnt,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    kind,
	output logic [7:0]                    reply_verb,
	output logic [7:0]                    reply_option,
	output logic [7:0]                    data_byte,
	output logic                          line_last,
	output logic                          line_empty,
	output logic                          line_truncated
);

	localparam int CW = $clog2(LINE_LEN + 1);
	localparam int IW = $clog2(LINE_LEN);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DUMP = 1'b1;

	logic          state_q, state_d;
	logic [CW-1:0] dcnt_q, dcnt_d;
	logic          dtrunc_q, dtrunc_d;
	logic [CW-1:0] rd_idx_q, rd_idx_d;
	logic [CW-1:0] em_idx_q, em_idx_d;
	logic          rd_pend_q, rd_pend_d;

	logic          out_valid_q;
	logic [2:0]    kind_q, n_kind;
	logic [7:0]    verb_q, n_verb;
	logic [7:0]    opt_q, n_opt;
	logic [7:0]    data_q, n_data;
	logic          last_q, n_last;
	logic          empty_q, n_empty;
	logic          trunc_q, n_trunc;

	logic          slot_free;
	logic          load;
	logic          issue;
	logic          ram_we;
	logic          ram_re;
	logic [CHAR_W-1:0] ram_rdata;

	tra_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(LINE_LEN)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(q_cnt[IW-1:0]),
		.wdata(q_cmd.value[CHAR_W-1:0]),
		.re   (ram_re),
		.raddr(rd_idx_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		q_pop     = 1'b0;
		load      = 1'b0;
		issue     = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		n_kind    = KIND_REPLY;
		n_verb    = '0;
		n_opt     = '0;
		n_data    = '0;
		n_last    = 1'b0;
		n_empty   = 1'b0;
		n_trunc   = 1'b0;
		state_d   = state_q;
		dcnt_d    = dcnt_q;
		dtrunc_d  = dtrunc_q;
		rd_idx_d  = rd_idx_q;
		em_idx_d  = em_idx_q;
		rd_pend_d = rd_pend_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					unique case (q_cmd.op)
						OP_REPLY: begin
							if (slot_free) begin
								q_pop  = 1'b1;
								load   = 1'b1;
								n_kind = KIND_REPLY;
								n_verb = q_cmd.verb;
								n_opt  = q_cmd.value;
							end
						end
						OP_STORE: begin
							if (!q_cmd.echo || slot_free) begin
								q_pop  = 1'b1;
								ram_we = 1'b1;
								load   = q_cmd.echo;
								n_kind = KIND_ECHO;
								n_data = q_cmd.value;
							end
						end
						OP_DUMP: begin
							q_pop     = 1'b1;
							state_d   = ST_DUMP;
							dcnt_d    = q_cnt;
							dtrunc_d  = q_cmd.trunc;
							rd_idx_d  = '0;
							em_idx_d  = '0;
							rd_pend_d = 1'b0;
						end
						OP_AYT: begin
							if (slot_free) begin
								q_pop  = 1'b1;
								load   = 1'b1;
								n_kind = KIND_AYT;
							end
						end
						OP_IP: begin
							if (slot_free) begin
								q_pop  = 1'b1;
								load   = 1'b1;
								n_kind = KIND_IP;
							end
						end
						default: q_pop = 1'b1;
					endcase
				end
			end
			ST_DUMP: begin
				n_kind  = KIND_LINE;
				n_trunc = dtrunc_q;
				if (dcnt_q == '0) begin
					if (slot_free) begin
						load    = 1'b1;
						n_last  = 1'b1;
						n_empty = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					// read data waits in the RAM output register until the slot frees
					load   = rd_pend_q && slot_free;
					n_data = {1'b0, ram_rdata};
					n_last = (em_idx_q + CW'(1) == dcnt_q);
					if (load) begin
						em_idx_d = em_idx_q + CW'(1);
						if (n_last) begin
							state_d = ST_IDLE;
						end
					end
					issue = (rd_idx_q < dcnt_q) && (!rd_pend_q || load);
					if (issue) begin
						ram_re   = 1'b1;
						rd_idx_d = rd_idx_q + CW'(1);
					end
					rd_pend_d = issue || (rd_pend_q && !load);
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_pend_q   <= rd_pend_d;
			out_valid_q <= load || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		dcnt_q   <= dcnt_d;
		dtrunc_q <= dtrunc_d;
		rd_idx_q <= rd_idx_d;
		em_idx_q <= em_idx_d;
		if (load) begin
			kind_q  <= n_kind;
			verb_q  <= n_verb;
			opt_q   <= n_opt;
			data_q  <= n_data;
			last_q  <= n_last;
			empty_q <= n_empty;
			trunc_q <= n_trunc;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign reply_verb     = verb_q;
	assign reply_option   = opt_q;
	assign data_byte      = data_q;
	assign line_last      = last_q;
	assign line_empty     = empty_q;
	assign line_truncated = trunc_q;

endmodule

>>> design/telnet_rx_line_assembler.sv
// Telnet receive line assembler: parser, request queue and executor.
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_ready   rx_byte
//   out      from block out_valid / out_ready kind, reply_verb, reply_option,
//                                             data_byte, line_last, line_empty,
//                                             line_truncated
//
// The parser takes one byte per cycle while the request queue has room; a result
// passes from the request queue through the executor into the output register.
// The executor retires one request per cycle while the output slot is free and no
// line dump runs; a line dump takes the request, issues the first line store read,
// then emits one item per stored character (one empty item for an empty line).
// Reset clears the parser, queue and executor control; the line store is not
// cleared, only written entries are ever read.
// A stalled output holds its register and the executor; the queue then fills
// and in_ready drops.
module telnet_rx_line_assembler
	import tra_pkg::*;
#(
	parameter int LINE_LEN = LINE_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] kind,
	output logic [7:0] reply_verb,
	output logic [7:0] reply_option,
	output logic [7:0] data_byte,
	output logic       line_last,
	output logic       line_empty,
	output logic       line_truncated
);

	`include "telnet_rx_line_assembler_assert.svh"

	localparam int CW = $clog2(LINE_LEN + 1);
	localparam int QW = $bits(cmd_t) + CW;

	cmd_t          f_cmd, b_cmd;
	logic [CW-1:0] f_cnt, b_cnt;
	logic          q_push, q_pop, q_full, q_empty;
	logic [QW-1:0] q_rdata;

	tra_front #(
		.LINE_LEN(LINE_LEN)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_byte (rx_byte),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_cmd   (f_cmd),
		.q_cnt   (f_cnt)
	);

	tra_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata ({f_cmd, f_cnt}),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign {b_cmd, b_cnt} = q_rdata;

	tra_back #(
		.LINE_LEN(LINE_LEN)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.q_cmd         (b_cmd),
		.q_cnt         (b_cnt),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.reply_verb    (reply_verb),
		.reply_option  (reply_option),
		.data_byte     (data_byte),
		.line_last     (line_last),
		.line_empty    (line_empty),
		.line_truncated(line_truncated)
	);

	`TRA_ASSERT_NOW(a_no_push_when_full, clk, arst_n, q_push, !q_full && in_valid,
		"request pushed into a full queue")
	`TRA_ASSERT_NOW(a_no_pop_when_empty, clk, arst_n, q_pop, !q_empty,
		"request popped from an empty queue")
	`TRA_ASSERT_NOW(a_empty_line_is_last, clk, arst_n,
		out_valid && kind == KIND_LINE && line_empty, line_last && data_byte == 8'd0,
		"empty line result not marked last")
	`TRA_ASSERT_NEXT(a_reply_fields_zero, clk, arst_n, 1'b1,
		!out_valid || kind == KIND_REPLY || (reply_verb == 8'd0 && reply_option == 8'd0),
		"reply fields set on a non-reply result")

endmodule

>>> tb/tb_telnet_rx_line_assembler.sv
// Testbench for the telnet receive line assembler: directed and random byte streams.
`timescale 1ns / 100ps

module tb_telnet_rx_line_assembler;
	import tra_pkg::*;

	localparam int LINE_LEN       = LINE_LEN_DEF;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 100;
	localparam int MAX_PRINTED    = 20;

	typedef enum logic [2:0] {
		PH_DATA,
		PH_CMD,
		PH_DO,
		PH_DONT,
		PH_WILL,
		PH_WONT
	} rx_phase_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] verb;
		logic [7:0] opt;
		logic [7:0] data;
		logic       last;
		logic       empty;
		logic       trunc;
	} tn_out_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] kind;
	logic [7:0] reply_verb;
	logic [7:0] reply_option;
	logic [7:0] data_byte;
	logic       line_last;
	logic       line_empty;
	logic       line_truncated;

	telnet_rx_line_assembler #(.LINE_LEN(LINE_LEN)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.reply_verb    (reply_verb),
		.reply_option  (reply_option),
		.data_byte     (data_byte),
		.line_last     (line_last),
		.line_empty    (line_empty),
		.line_truncated(line_truncated)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// predicted receiver state
	rx_phase_t          parse_ph = PH_DATA;
	logic [CHAR_W-1:0]  line_mem [LINE_LEN];
	int                 line_len = 0;
	bit                 line_trunc = 1'b0;
	bit                 echo_en = 1'b0;
	bit                 eor_en = 1'b0;
	bit                 ga_en = 1'b1;
	bit                 sga_refused_seen = 1'b0;

	tn_out_t tn_out_due [$];

	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int rx_hold = 0;
	int error_count = 0;
	int n_rx_taken = 0;
	int n_checked = 0;
	int n_lines = 0;
	int n_trunc_lines = 0;
	int n_replies = 0;
	int n_echoes = 0;
	int n_ayt_ip = 0;

	function automatic void push_result(logic [2:0] k, logic [7:0] verb, logic [7:0] opt,
			logic [7:0] data, logic last, logic empty, logic trunc);
		tn_out_t r;
		r.kind  = k;
		r.verb  = verb;
		r.opt   = opt;
		r.data  = data;
		r.last  = last;
		r.empty = empty;
		r.trunc = trunc;
		tn_out_due.push_back(r);
	endfunction

	function automatic void predict_rx_byte(logic [7:0] b);
		case (parse_ph)
			PH_CMD: begin
				parse_ph = PH_DATA;
				if (b == TN_AYT)
					push_result(KIND_AYT, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
				else if (b == TN_IP)
					push_result(KIND_IP, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
				else if (b == TN_EC) begin
					if (line_len > 0)
						line_len--;
				end else if (b == TN_EL) begin
					line_len = 0;
					line_trunc = 1'b0;
				end else if (b == TN_DO)
					parse_ph = PH_DO;
				else if (b == TN_DONT)
					parse_ph = PH_DONT;
				else if (b == TN_WILL)
					parse_ph = PH_WILL;
				else if (b == TN_WONT)
					parse_ph = PH_WONT;
			end
			PH_DO: begin
				parse_ph = PH_DATA;
				if (b == OPT_SGA)
					ga_en = 1'b0;
				else if (b == OPT_EOR)
					eor_en = 1'b1;
				else if (b == OPT_ECHO)
					echo_en = 1'b1;
				if (b == OPT_SGA || b == OPT_EOR || b == OPT_ECHO)
					push_result(KIND_REPLY, TN_WILL, b, 8'd0, 1'b0, 1'b0, 1'b0);
				else
					push_result(KIND_REPLY, TN_WONT, b, 8'd0, 1'b0, 1'b0, 1'b0);
			end
			PH_DONT: begin
				parse_ph = PH_DATA;
				if (b == OPT_SGA)
					sga_refused_seen = 1'b1;
				else if (b == OPT_EOR)
					eor_en = 1'b0;
				else if (b == OPT_ECHO)
					echo_en = 1'b0;
			end
			PH_WILL: begin
				parse_ph = PH_DATA;
				push_result(KIND_REPLY, TN_DONT, b, 8'd0, 1'b0, 1'b0, 1'b0);
			end
			PH_WONT: begin
				parse_ph = PH_DATA;
			end
			default: begin
				if (b == TN_IAC)
					parse_ph = PH_CMD;
				else if (b == CH_LF) begin
					if (line_len == 0)
						push_result(KIND_LINE, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, line_trunc);
					else
						for (int k = 0; k < line_len; k++)
							push_result(KIND_LINE, 8'd0, 8'd0, {1'b0, line_mem[k]},
								k + 1 == line_len, 1'b0, line_trunc);
					line_len = 0;
					line_trunc = 1'b0;
				end else if (b == CH_BS || b == CH_DEL) begin
					if (line_len > 0)
						line_len--;
				end else if (b > CH_CTL && b < CH_DEL) begin
					// a full line drops the character silently, no echo
					if (line_len >= LINE_LEN)
						line_trunc = 1'b1;
					else begin
						line_mem[line_len] = b[CHAR_W-1:0];
						line_len++;
						if (echo_en)
							push_result(KIND_ECHO, 8'd0, 8'd0, b, 1'b0, 1'b0, 1'b0);
					end
				end
			end
		endcase
	endfunction

	function automatic int pick_gap(bit idle_on);
		int r;
		r = $urandom_range(99);
		if (!idle_on || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// one byte request; valid is only dropped when a gap is inserted
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap(tx_idle);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (!in_ready);
		predict_rx_byte(b);
		n_rx_taken++;
	endtask

	task automatic check_result();
		tn_out_t want;
		if (tn_out_due.size() == 0) begin
			report_mismatch($sformatf("unexpected result kind %0d data %0d", kind, data_byte));
			return;
		end
		want = tn_out_due.pop_front();
		n_checked++;
		if (kind !== want.kind)
			report_mismatch($sformatf("kind got %0d want %0d", kind, want.kind));
		if (reply_verb !== want.verb)
			report_mismatch($sformatf("reply_verb got %0d want %0d", reply_verb, want.verb));
		if (reply_option !== want.opt)
			report_mismatch($sformatf("reply_option got %0d want %0d", reply_option, want.opt));
		if (data_byte !== want.data)
			report_mismatch($sformatf("data_byte got %0d want %0d", data_byte, want.data));
		if (line_last !== want.last)
			report_mismatch($sformatf("line_last got %0b want %0b", line_last, want.last));
		if (line_empty !== want.empty)
			report_mismatch($sformatf("line_empty got %0b want %0b", line_empty, want.empty));
		if (line_truncated !== want.trunc)
			report_mismatch($sformatf("line_truncated got %0b want %0b",
				line_truncated, want.trunc));
		case (want.kind)
			KIND_REPLY: n_replies++;
			KIND_ECHO:  n_echoes++;
			KIND_LINE: begin
				if (want.last)
					n_lines++;
				if (want.last && want.trunc)
					n_trunc_lines++;
			end
			default:    n_ayt_ip++;
		endcase
	endtask

	// result side: check on accept, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_result();
		if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			rx_hold = pick_gap(rx_idle);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog expired with %0d results outstanding", tn_out_due.size());
		$display("tb_telnet_rx_line_assembler NOT OK");
		$finish;
	end

	task automatic test_negotiation();
		send_byte(TN_IAC); send_byte(TN_DO);   send_byte(OPT_ECHO);
		send_byte(TN_IAC); send_byte(TN_DO);   send_byte(TN_IAC);
		send_byte(TN_IAC); send_byte(TN_WILL); send_byte(8'd0);
		// option byte is taken even when it is IAC
		send_byte(TN_IAC); send_byte(TN_WONT); send_byte(TN_IAC);
		send_byte(TN_IAC); send_byte(TN_DONT); send_byte(8'd200);
	endtask

	task automatic test_line_edit();
		send_byte(8'h20); send_byte(8'h7e);
		send_byte(CH_BS); send_byte(CH_DEL); send_byte(CH_BS);
		send_byte(8'h0d); send_byte(8'hc3);
		send_byte(CH_LF);
		send_byte(8'h41); send_byte(TN_IAC); send_byte(TN_EC);
		send_byte(TN_IAC); send_byte(TN_EC);
		send_byte(8'h42); send_byte(CH_LF);
	endtask

	task automatic test_overflow();
		repeat (LINE_LEN + 1)
			send_byte(8'($urandom_range(32, 126)));
		send_byte(CH_LF);
		repeat (LINE_LEN + 2)
			send_byte(8'($urandom_range(32, 126)));
		// erase line clears the truncation mark
		send_byte(TN_IAC); send_byte(TN_EL);
		send_byte(8'h7a); send_byte(CH_LF);
	endtask

	task automatic test_commands();
		send_byte(TN_IAC); send_byte(TN_AYT);
		send_byte(TN_IAC); send_byte(TN_IP);
		send_byte(TN_IAC); send_byte(TN_IAC);
		send_byte(TN_IAC); send_byte(TN_DONT); send_byte(OPT_ECHO);
		send_byte(TN_IAC); send_byte(TN_DO);   send_byte(OPT_SGA);
		send_byte(TN_IAC); send_byte(TN_DO);   send_byte(OPT_EOR);
		send_byte(TN_IAC); send_byte(TN_DONT); send_byte(OPT_SGA);
		send_byte(TN_IAC); send_byte(TN_DONT); send_byte(OPT_EOR);
		send_byte(8'h31); send_byte(CH_LF);
	endtask

	task automatic test_random_traffic(input int n_items);
		int sent;
		int len;
		int sel;
		int r;
		logic [7:0] b;
		sent = 0;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		while (sent < n_items) begin
			if ($urandom_range(7) == 0)
				tx_idle = !tx_idle;
			if ($urandom_range(7) == 0)
				rx_idle = !rx_idle;
			sel = $urandom_range(99);
			if (sel < 50) begin
				if ($urandom_range(9) == 0)
					len = $urandom_range(LINE_LEN - 2, LINE_LEN + 6);
				else
					len = $urandom_range(0, 10);
				for (int k = 0; k < len; k++) begin
					r = $urandom_range(19);
					if (r == 0)
						b = $urandom_range(1) ? CH_BS : CH_DEL;
					else if (r == 1) begin
						send_byte(TN_IAC);
						sent++;
						b = $urandom_range(3) == 0 ? TN_EL : TN_EC;
					end else if (r == 2) begin
						b = 8'($urandom_range(0, 31));
						if (b == CH_LF)
							b = 8'h0d;
					end else
						b = 8'($urandom_range(32, 126));
					send_byte(b);
					sent++;
				end
				send_byte(CH_LF);
				sent++;
			end else if (sel < 75) begin
				send_byte(TN_IAC);
				case ($urandom_range(3))
					0: send_byte(TN_DO);
					1: send_byte(TN_DONT);
					2: send_byte(TN_WILL);
					default: send_byte(TN_WONT);
				endcase
				case ($urandom_range(4))
					0, 1: send_byte(OPT_ECHO);
					2: send_byte(OPT_SGA);
					3: send_byte(OPT_EOR);
					default: send_byte(8'($urandom_range(255)));
				endcase
				sent += 3;
			end else if (sel < 88) begin
				send_byte(TN_IAC);
				case ($urandom_range(4))
					0: send_byte(TN_AYT);
					1: send_byte(TN_IP);
					2: send_byte(TN_EC);
					3: send_byte(TN_EL);
					default: send_byte(8'($urandom_range(255)));
				endcase
				sent += 2;
			end else begin
				// noise, may also open a command that swallows the next byte
				send_byte(8'($urandom_range(255)));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		rx_byte  = 8'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_negotiation();
		test_line_edit();
		test_overflow();
		test_commands();
		test_random_traffic(200);
		in_valid <= 1'b0;
		rx_idle = 1'b0;
		while (tn_out_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d bytes, checked %0d results: %0d lines (%0d truncated),",
			n_rx_taken, n_checked, n_lines, n_trunc_lines);
		$display("%0d negotiation replies, %0d echoes, %0d AYT/IP, %0d mismatches",
			n_replies, n_echoes, n_ayt_ip, error_count);
		if (error_count == 0)
			$display("tb_telnet_rx_line_assembler OK");
		else
			$display("tb_telnet_rx_line_assembler NOT OK");
		$finish;
	end

endmodule
